// File: hdl/slgc_pkg.sv
`default_nettype none

package slgc_pkg;

	// Default sizes of the palette and of the gradient stop table.
	localparam int PALETTE_SIZE_DEF = 256;
	localparam int STOP_COUNT_DEF = 13;

	// Widths of the level configuration registers and of the APB port.
	localparam int LEVEL_CFG_W = 9;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register indexes, taken from the word address bit of the APB port.
	localparam logic REG_MIN_LEVEL = 1'b0;
	localparam logic REG_MAX_LEVEL = 1'b1;

	// Reset values of the displayed range, in whole dB.
	localparam logic signed [LEVEL_CFG_W-1:0] MIN_LEVEL_RST = -9'sd100;
	localparam logic signed [LEVEL_CFG_W-1:0] MAX_LEVEL_RST = 9'sd0;

	// Gradient stop table, packed as red, green, blue. Entries past the last
	// real stop repeat it.
	function automatic logic [23:0] stop_color(input logic [3:0] idx);
		logic [23:0] col;
		unique case (idx)
			4'd0: col = 24'h000020;
			4'd1: col = 24'h000030;
			4'd2: col = 24'h000050;
			4'd3: col = 24'h000091;
			4'd4: col = 24'h1E90FF;
			4'd5: col = 24'hFFFFFF;
			4'd6: col = 24'hFFFF00;
			4'd7: col = 24'hFE6D16;
			4'd8: col = 24'hFF0000;
			4'd9: col = 24'hC60000;
			4'd10: col = 24'h9F0000;
			4'd11: col = 24'h750000;
			default: col = 24'h4A0000;
		endcase
		return col;
	endfunction

endpackage

`default_nettype wire

// File: hdl/spectrum_level_to_gradient_color.sv
// A level beat passes the clamp, scale, divider, stop, weight, sum, reciprocal and output
// stages to its pixel beat; the restoring divider spends one stage per index bit.
// Throughput: one beat per cycle unless the output stalls; each stage holds one beat and
// fills any bubble ahead. Reset: arst_n clears all stage valid bits at once and sets the
// range to -100 dB .. 0 dB. No clearing pass is needed; level_ready is high once reset ends.
`default_nettype none

module spectrum_level_to_gradient_color import slgc_pkg::*; #(
	parameter int PALETTE_SIZE = PALETTE_SIZE_DEF,
	parameter int STOP_COUNT = STOP_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [APB_ADDR_W-1:0]         paddr,
	input  wire logic [APB_DATA_W-1:0]         pwdata,
	output logic      [APB_DATA_W-1:0]         prdata,
	output logic                               pready,
	// Level channel.
	input  wire logic                          level_valid,
	output logic                               level_ready,
	input  wire logic signed [15:0]            level_db,
	input  wire logic                          last_bin,
	// Pixel channel.
	output logic                               pixel_valid,
	input  wire logic                          pixel_ready,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	output logic [7:0]                         palette_index,
	output logic                               row_end
);

	// Widths that follow from the palette size.
	localparam int IW = $clog2(PALETTE_SIZE);
	localparam int XW = 17;
	localparam int NW = XW + IW;
	localparam int TW = IW + 5;
	localparam int VW = 8 + IW;
	localparam int MW = 2 * VW + 1;
	localparam int KSH = VW + IW;
	localparam logic [63:0] RECIP64 =
		((64'd1 << KSH) + 64'(PALETTE_SIZE) - 64'd1) / 64'(PALETTE_SIZE);
	localparam logic [VW:0] RECIP = RECIP64[VW:0];

	// Stage positions in the valid vector.
	localparam int ST1 = 0;
	localparam int ST2 = 1;
	localparam int ST3 = 2;
	localparam int ST4 = IW + 2;
	localparam int ST5 = IW + 3;
	localparam int ST6 = IW + 4;
	localparam int ST7 = IW + 5;
	localparam int ST8 = IW + 6;
	localparam int NS = IW + 7;

	logic signed [LEVEL_CFG_W-1:0] min_q;
	logic signed [LEVEL_CFG_W-1:0] max_q;
	logic                          cfg_wr;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] last_s;
	logic [NS-1:0] en;
	logic [NS-1:0] vld_prev;
	logic [NS-1:0] last_prev;
	logic [NS-1:0] drain;
	logic          stall;

	// Configuration registers; the word address picks the register.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_LEVEL_RST;
			max_q <= MAX_LEVEL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MIN_LEVEL: min_q <= pwdata[LEVEL_CFG_W-1:0];
				REG_MAX_LEVEL: max_q <= pwdata[LEVEL_CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MIN_LEVEL: prdata = {{(APB_DATA_W-LEVEL_CFG_W){min_q[8]}}, min_q};
			REG_MAX_LEVEL: prdata = {{(APB_DATA_W-LEVEL_CFG_W){max_q[8]}}, max_q};
		endcase
	end

	// Flow control: the whole pipe stalls only while the output beat waits, but any
	// empty stage still takes the beat behind it.
	assign stall = vld_s[ST8] & ~pixel_ready;
	assign en = {NS{~stall}} | ~vld_s;
	assign vld_prev = {vld_s[NS-2:0], level_valid};
	assign last_prev = {last_s[NS-2:0], last_bin};
	assign drain = {pixel_ready, en[NS-1:1]};
	assign level_ready = en[ST1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (en & vld_prev) | (~en & vld_s & ~drain);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (en[k]) begin
				last_s[k] <= last_prev[k];
			end
		end
	end

	// Stage 1: clamp the level to the range and take its offset from the minimum.
	logic signed [17:0] lo_w;
	logic signed [17:0] hi_w;
	logic signed [17:0] lvl_w;
	logic signed [17:0] clp_w;
	logic signed [17:0] off_w;
	logic signed [17:0] span_w;
	logic               empty_w;
	logic [XW-1:0]      x_s1;
	logic [XW-1:0]      den_s1;

	assign lo_w = {min_q[8], min_q, 8'd0};
	assign hi_w = {max_q[8], max_q, 8'd0};
	assign lvl_w = {{2{level_db[15]}}, level_db};
	assign empty_w = max_q <= min_q;

	always_comb begin
		if (lvl_w < lo_w) begin
			clp_w = lo_w;
		end else if (lvl_w > hi_w) begin
			clp_w = hi_w;
		end else begin
			clp_w = lvl_w;
		end
		off_w = clp_w - lo_w;
		span_w = hi_w - lo_w;
	end

	always_ff @(posedge clk) begin
		if (en[ST1]) begin
			x_s1 <= empty_w ? '0 : off_w[XW-1:0];
			den_s1 <= empty_w ? XW'(1) : span_w[XW-1:0];
		end
	end

	// Stage 2: scale the offset by the last palette index.
	localparam logic [IW-1:0] PMAX = IW'(PALETTE_SIZE - 1);
	logic [NW-1:0] num_s2;
	logic [XW-1:0] den_s2;

	always_ff @(posedge clk) begin
		if (en[ST2]) begin
			num_s2 <= {IW'(0), x_s1} * {XW'(0), PMAX};
			den_s2 <= den_s1;
		end
	end

	// Stage 3: restoring divider, one quotient bit per stage, most significant first.
	logic [NW-1:0] div_rem_s3 [IW];
	logic [XW-1:0] div_den_s3 [IW];
	logic [IW-1:0] div_quo_s3 [IW];

	for (genvar j = 0; j < IW; j++) begin : g_div
		localparam int BIT = IW - 1 - j;
		logic [NW-1:0] rem_in;
		logic [XW-1:0] den_in;
		logic [IW-1:0] quo_in;
		logic [NW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in = num_s2;
			assign den_in = den_s2;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = div_rem_s3[j-1];
			assign den_in = div_den_s3[j-1];
			assign quo_in = div_quo_s3[j-1];
		end

		assign trial = {IW'(0), den_in} << BIT;
		assign ge = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en[ST3+j]) begin
				div_rem_s3[j] <= ge ? rem_in - trial : rem_in;
				div_den_s3[j] <= den_in;
				div_quo_s3[j] <= quo_in | (IW'(ge) << BIT);
			end
		end
	end

	// Stage 4: find the pair of neighboring stops and the weight between them.
	logic [TW-1:0] t_w;
	logic [TW-1:0] base_w;
	logic [3:0]    lo_w4;
	logic [IW-1:0] rem_w4;
	logic [3:0]    hi_w4;
	logic [3:0]    lo_s4;
	logic [3:0]    hi_s4;
	logic [IW-1:0] rem_s4;
	logic [IW-1:0] idx_s4;

	assign t_w = TW'(div_quo_s3[IW-1]) * TW'(STOP_COUNT);

	always_comb begin
		lo_w4 = '0;
		base_w = '0;
		for (int k = 1; k < STOP_COUNT; k++) begin
			if (t_w >= TW'(k * PALETTE_SIZE)) begin
				lo_w4 = 4'(k);
				base_w = TW'(k * PALETTE_SIZE);
			end
		end
		rem_w4 = IW'(t_w - base_w);
		if (rem_w4 != '0 && lo_w4 != 4'(STOP_COUNT - 1)) begin
			hi_w4 = lo_w4 + 4'd1;
		end else begin
			hi_w4 = lo_w4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST4]) begin
			lo_s4 <= lo_w4;
			hi_s4 <= hi_w4;
			rem_s4 <= rem_w4;
			idx_s4 <= div_quo_s3[IW-1];
		end
	end

	// Stage 5: weight both stop colors of every channel.
	logic [23:0]   col_lo;
	logic [23:0]   col_hi;
	logic [IW:0]   wt_lo;
	logic [VW-1:0] pa_s5 [3];
	logic [VW-1:0] pb_s5 [3];
	logic [IW-1:0] idx_s5;

	assign col_lo = stop_color(lo_s4);
	assign col_hi = stop_color(hi_s4);
	assign wt_lo = (IW+1)'(PALETTE_SIZE) - {1'b0, rem_s4};

	always_ff @(posedge clk) begin
		if (en[ST5]) begin
			for (int c = 0; c < 3; c++) begin
				pa_s5[c] <= VW'(col_lo[8*(2-c) +: 8]) * VW'(wt_lo);
				pb_s5[c] <= VW'(col_hi[8*(2-c) +: 8]) * VW'(rem_s4);
			end
			idx_s5 <= idx_s4;
		end
	end

	// Stage 6: sum the two weighted colors.
	logic [VW-1:0] v_s6 [3];
	logic [IW-1:0] idx_s6;

	always_ff @(posedge clk) begin
		if (en[ST6]) begin
			for (int c = 0; c < 3; c++) begin
				v_s6[c] <= pa_s5[c] + pb_s5[c];
			end
			idx_s6 <= idx_s5;
		end
	end

	// Stage 7: divide by the palette size through a multiply by its reciprocal.
	logic [MW-1:0] prod_s7 [3];
	logic [IW-1:0] idx_s7;

	always_ff @(posedge clk) begin
		if (en[ST7]) begin
			for (int c = 0; c < 3; c++) begin
				prod_s7[c] <= MW'(v_s6[c]) * MW'(RECIP);
			end
			idx_s7 <= idx_s6;
		end
	end

	// Stage 8: output register.
	logic [7:0] chan_s8 [3];
	logic [7:0] idx_s8;

	always_ff @(posedge clk) begin
		if (en[ST8]) begin
			for (int c = 0; c < 3; c++) begin
				chan_s8[c] <= prod_s7[c][KSH +: 8];
			end
			idx_s8 <= 8'(idx_s7);
		end
	end

	assign pixel_valid = vld_s[ST8];
	assign red = chan_s8[0];
	assign green = chan_s8[1];
	assign blue = chan_s8[2];
	assign palette_index = idx_s8;
	assign row_end = last_s[ST8];

`ifndef SYNTHESIS
	// The input side only blocks while a finished pixel waits at the output.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!level_ready |-> pixel_valid && !pixel_ready)
		else $error("level_ready low without an output stall");

	// The divider never yields an index beyond the palette.
	a_quotient_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST4-1] |-> div_quo_s3[IW-1] <= PMAX)
		else $error("palette index out of range after division");

	// The selected stops stay in the table and are neighbors.
	a_stops_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST4] |-> lo_s4 <= 4'(STOP_COUNT - 1) && (4'(hi_s4 - lo_s4) <= 4'd1))
		else $error("stop pair not adjacent");

	// An exact hit on a stop uses that stop alone.
	a_exact_stop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST4] && rem_s4 == '0 |-> hi_s4 == lo_s4)
		else $error("stop pair split on an exact stop");
`endif

endmodule

`default_nettype wire
